// ----- rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check clocked on clk, off while rst_n is low.
`define RHC_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rhc assertion failed");

// Antecedent in one cycle implies consequent in the next.
`define RHC_ASSERT_NEXT(lbl, ante, cons) \
    `RHC_ASSERT(lbl, (ante) |=> (cons))

`endif

// ----- rtl/rhc_pkg.sv -----
package rhc_pkg;

    localparam int VB = 16;
    localparam int DQ_W = VB + 1;
    localparam int DVD_W = 2 * VB + 4;
    localparam int DVS_W = VB + 3;
    localparam int HSL_STAGES = 5;
    localparam int RGB_FRONT = 2;
    localparam int OP_DELAY = RGB_FRONT + DQ_W;
    localparam int HSL_PAD = RGB_FRONT + DQ_W - HSL_STAGES;

    typedef logic [VB-1:0] val_t;

    localparam val_t FULL = '1;

    localparam logic OP_RGB2HSL = 1'b0;
    localparam logic OP_HSL2RGB = 1'b1;

    localparam logic [2:0] SEC_RY = 3'd0;
    localparam logic [2:0] SEC_YG = 3'd1;
    localparam logic [2:0] SEC_GC = 3'd2;
    localparam logic [2:0] SEC_CB = 3'd3;
    localparam logic [2:0] SEC_BM = 3'd4;

    typedef enum logic [1:0] {
        HUE_RED   = 2'd0,
        HUE_GREEN = 2'd1,
        HUE_BLUE  = 2'd2
    } hue_sec_t;

    typedef struct packed {
        val_t c0;
        val_t c1;
        val_t c2;
    } trip_t;

    typedef struct packed {
        val_t light;
        logic zero_c;
        logic sat_ok;
    } rgb_side_t;

endpackage

// ----- rtl/rhc_div.sv -----
`include "assert_macros.svh"

module rhc_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [rhc_pkg::DVD_W-1:0]    dividend,
    input  logic [rhc_pkg::DVS_W-1:0]    divisor,
    output logic                         out_valid,
    output logic [rhc_pkg::DQ_W-1:0]     quotient
);

    localparam int QW = rhc_pkg::DQ_W;
    localparam int DW = rhc_pkg::DVD_W;
    localparam int SW = rhc_pkg::DVS_W;

    logic          v_reg   [QW];
    logic [DW-1:0] rem_reg [QW];
    logic [SW-1:0] dvs_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        localparam int J = QW - 1 - k;
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [SW-1:0] dvs_in;
        logic [QW-1:0] q_in;
        logic [DW:0]   shifted;
        logic [DW:0]   diff;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in   = in_valid;
            assign rem_in = dividend;
            assign dvs_in = divisor;
            assign q_in   = '0;
        end
        else begin : g_next
            assign v_in   = v_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign q_in   = q_reg[k-1];
        end

        assign shifted = (DW + 1)'(dvs_in) << J;
        assign diff    = {1'b0, rem_in} - shifted;
        assign ge      = !diff[DW];

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk) begin
            if (en)
            begin
                rem_reg[k] <= ge ? diff[DW-1:0] : rem_in;
                dvs_reg[k] <= dvs_in;
                q_reg[k]   <= q_in | (QW'(ge) << J);
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign quotient  = q_reg[QW-1];

    `RHC_ASSERT(a_rem_below_divisor, (v_reg[QW-1] && dvs_reg[QW-1] != '0) |-> (rem_reg[QW-1] < DW'(dvs_reg[QW-1])))

endmodule

// ----- rtl/rhc_hsl2rgb.sv -----
module rhc_hsl2rgb (
    input  logic                 clk,
    input  logic                 en,
    input  rhc_pkg::val_t        hue,
    input  rhc_pkg::val_t        sat,
    input  rhc_pkg::val_t        light,
    output rhc_pkg::trip_t       rgb
);

    localparam int VB = rhc_pkg::VB;
    localparam int NW = 2 * VB + 4;

    // stage 1
    logic [VB:0]   twice;
    logic [VB:0]   spread;
    logic [VB+2:0] six;
    logic [VB:0]   xfac;
    rhc_pkg::val_t h1_span_reg, h1_sat_reg, h1_l_reg;
    logic [2:0]    h1_sec_reg;
    logic [VB:0]   h1_xfac_reg;

    assign twice  = {light, 1'b0};
    assign spread = (twice > {1'b0, rhc_pkg::FULL}) ? twice - {1'b0, rhc_pkg::FULL}
                                                    : {1'b0, rhc_pkg::FULL} - twice;
    assign six    = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    assign xfac   = six[VB] ? ((VB + 1)'(1) << VB) - {1'b0, six[VB-1:0]}
                            : {1'b0, six[VB-1:0]};

    always_ff @(posedge clk) begin
        if (en)
        begin
            h1_span_reg <= rhc_pkg::FULL - spread[VB-1:0];
            h1_sat_reg  <= sat;
            h1_l_reg    <= light;
            h1_sec_reg  <= six[VB+2:VB];
            h1_xfac_reg <= xfac;
        end
    end

    // stage 2
    logic [2*VB-1:0] h2_cn_reg;
    rhc_pkg::val_t   h2_l_reg;
    logic [2:0]      h2_sec_reg;
    logic [VB:0]     h2_xfac_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            h2_cn_reg   <= h1_span_reg * h1_sat_reg;
            h2_l_reg    <= h1_l_reg;
            h2_sec_reg  <= h1_sec_reg;
            h2_xfac_reg <= h1_xfac_reg;
        end
    end

    // stage 3
    logic [2*VB-1:0] xr;
    logic [VB-1:0]   q0;
    logic [VB:0]     r0;
    logic [VB:0]     cq;
    rhc_pkg::val_t   h3_c_reg, h3_l_reg;
    logic [2:0]      h3_sec_reg;
    logic [VB:0]     h3_xfac_reg;

    assign xr = h2_cn_reg + (2 * VB)'(rhc_pkg::FULL >> 1);
    assign q0 = xr[2*VB-1:VB];
    assign r0 = {1'b0, xr[VB-1:0]} + {1'b0, q0};
    assign cq = (r0 >= {1'b0, rhc_pkg::FULL}) ? {1'b0, q0} + 1'b1 : {1'b0, q0};

    always_ff @(posedge clk) begin
        if (en)
        begin
            h3_c_reg    <= cq[VB] ? rhc_pkg::FULL : cq[VB-1:0];
            h3_l_reg    <= h2_l_reg;
            h3_sec_reg  <= h2_sec_reg;
            h3_xfac_reg <= h2_xfac_reg;
        end
    end

    // stage 4
    logic signed [NW-1:0] h4_base_reg, h4_cterm_reg, h4_xterm_reg;
    logic [2:0]           h4_sec_reg;
    logic [2*VB:0]        xprod;

    assign xprod = h3_c_reg * h3_xfac_reg;

    always_ff @(posedge clk) begin
        if (en)
        begin
            h4_base_reg  <= $signed({3'b000, h3_l_reg, {(VB + 1){1'b0}}})
                          - $signed({4'b0000, h3_c_reg, {VB{1'b0}}});
            h4_cterm_reg <= $signed({3'b000, h3_c_reg, {(VB + 1){1'b0}}});
            h4_xterm_reg <= $signed({2'b00, xprod, 1'b0});
            h4_sec_reg   <= h3_sec_reg;
        end
    end

    // stage 5
    logic signed [NW-1:0] rn, gn, bn;
    logic signed [NW-1:0] h5_rn_reg, h5_gn_reg, h5_bn_reg;

    always_comb begin
        rn = h4_base_reg;
        gn = h4_base_reg;
        bn = h4_base_reg;
        unique case (h4_sec_reg)
            rhc_pkg::SEC_RY:
            begin
                rn = h4_base_reg + h4_cterm_reg;
                gn = h4_base_reg + h4_xterm_reg;
            end
            rhc_pkg::SEC_YG:
            begin
                rn = h4_base_reg + h4_xterm_reg;
                gn = h4_base_reg + h4_cterm_reg;
            end
            rhc_pkg::SEC_GC:
            begin
                gn = h4_base_reg + h4_cterm_reg;
                bn = h4_base_reg + h4_xterm_reg;
            end
            rhc_pkg::SEC_CB:
            begin
                gn = h4_base_reg + h4_xterm_reg;
                bn = h4_base_reg + h4_cterm_reg;
            end
            rhc_pkg::SEC_BM:
            begin
                rn = h4_base_reg + h4_xterm_reg;
                bn = h4_base_reg + h4_cterm_reg;
            end
            default:
            begin
                rn = h4_base_reg + h4_cterm_reg;
                bn = h4_base_reg + h4_xterm_reg;
            end
        endcase
    end

    always_ff @(posedge clk) begin
        if (en)
        begin
            h5_rn_reg <= rn;
            h5_gn_reg <= gn;
            h5_bn_reg <= bn;
        end
    end

    function automatic rhc_pkg::val_t finish(input logic signed [NW-1:0] n);
        logic [NW-1:0] t;
        logic [NW-1:0] v;
        t = $unsigned(n) + (NW'(1) << VB);
        v = t >> (VB + 1);
        if (n[NW-1])
            return '0;
        else if (v > NW'(rhc_pkg::FULL))
            return rhc_pkg::FULL;
        else
            return v[VB-1:0];
    endfunction

    assign rgb.c0 = finish(h5_rn_reg);
    assign rgb.c1 = finish(h5_gn_reg);
    assign rgb.c2 = finish(h5_bn_reg);

endmodule

// ----- rtl/rgb_hsl_colour_converter.sv -----
// RGB <-> HSL colour converter, one colour per request.
// Input channel: in_valid/in_ready with opcode, first_value, second_value,
// third_value and alpha_in. Opcode RGB-to-HSL reads red, green, blue and
// returns hue, saturation, lightness; opcode HSL-to-RGB does the reverse.
// Output channel: out_valid/out_ready with first_result, second_result,
// third_result and alpha_out (alpha copied unchanged).
// Path: the request passes the input register, two front stages, the
// 17-step pipelined divider that forms hue and saturation one quotient
// bit per stage, and the output register. HSL-to-RGB items run a
// five-stage multiply path and are padded by alignment registers to match,
// so results leave in request order.
// Throughput: one request per cycle while out_ready is high.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline comes up empty with in_ready
// high and out_valid low.
`include "assert_macros.svh"

module rgb_hsl_colour_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] first_value,
    input  logic [15:0] second_value,
    input  logic [15:0] third_value,
    input  logic [15:0] alpha_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] first_result,
    output logic [15:0] second_result,
    output logic [15:0] third_result,
    output logic [15:0] alpha_out
);

    localparam int VB = rhc_pkg::VB;
    localparam int DW = rhc_pkg::DVD_W;
    localparam int SW = rhc_pkg::DVS_W;
    localparam int QW = rhc_pkg::DQ_W;

    logic enable;
    logic out_valid_reg;

    assign enable   = !out_valid_reg || out_ready;
    assign in_ready = enable;

    // input register
    logic          s1_valid_reg;
    logic          s1_op_reg;
    rhc_pkg::val_t s1_a_reg, s1_b_reg, s1_c_reg, s1_alpha_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (enable)
        begin
            s1_op_reg    <= opcode;
            s1_a_reg     <= first_value[VB-1:0];
            s1_b_reg     <= second_value[VB-1:0];
            s1_c_reg     <= third_value[VB-1:0];
            s1_alpha_reg <= alpha_in[VB-1:0];
        end
    end

    // stage A: extremes, chroma, sector
    rhc_pkg::val_t     mx_rg, mn_rg, mx, mn;
    rhc_pkg::hue_sec_t sel;
    logic              a_valid_reg;
    rhc_pkg::val_t     a_r_reg, a_g_reg, a_b_reg, a_c_reg;
    logic [VB:0]       a_sum_reg;
    rhc_pkg::hue_sec_t a_sel_reg;

    assign mx_rg = (s1_a_reg >= s1_b_reg) ? s1_a_reg : s1_b_reg;
    assign mx    = (mx_rg >= s1_c_reg) ? mx_rg : s1_c_reg;
    assign mn_rg = (s1_a_reg <= s1_b_reg) ? s1_a_reg : s1_b_reg;
    assign mn    = (mn_rg <= s1_c_reg) ? mn_rg : s1_c_reg;

    always_comb begin
        priority if (mx == s1_a_reg)
            sel = rhc_pkg::HUE_RED;
        else if (mx == s1_b_reg)
            sel = rhc_pkg::HUE_GREEN;
        else
            sel = rhc_pkg::HUE_BLUE;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            a_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (enable)
        begin
            a_r_reg   <= s1_a_reg;
            a_g_reg   <= s1_b_reg;
            a_b_reg   <= s1_c_reg;
            a_c_reg   <= mx - mn;
            a_sum_reg <= {1'b0, mx} + {1'b0, mn};
            a_sel_reg <= sel;
        end
    end

    // stage B: divider operands
    localparam logic [VB:0] TWO_F = {rhc_pkg::FULL, 1'b0};

    logic signed [VB+3:0] raw;
    logic [VB+2:0]        c6;
    logic [VB+2:0]        num;
    logic [VB+1:0]        c3;
    logic [VB:0]          other;
    logic [VB:0]          den;
    logic [VB:0]          sum1;
    rhc_pkg::rgb_side_t   side;

    logic                 b_valid_reg;
    logic [DW-1:0]        b_hue_dvd_reg, b_sat_dvd_reg;
    logic [SW-1:0]        b_hue_dvs_reg, b_sat_dvs_reg;
    rhc_pkg::rgb_side_t   b_side_reg;

    assign c6 = {1'b0, a_c_reg, 2'b00} + {2'b00, a_c_reg, 1'b0};
    assign c3 = {1'b0, a_c_reg, 1'b0} + {2'b00, a_c_reg};

    always_comb begin
        unique case (a_sel_reg)
            rhc_pkg::HUE_RED:
            begin
                raw = $signed({4'b0000, a_g_reg}) - $signed({4'b0000, a_b_reg});
                if (raw < 0)
                    raw = raw + $signed({1'b0, c6});
            end
            rhc_pkg::HUE_GREEN:
            begin
                raw = $signed({3'b000, a_c_reg, 1'b0}) + $signed({4'b0000, a_b_reg})
                    - $signed({4'b0000, a_r_reg});
            end
            default:
            begin
                raw = $signed({2'b00, a_c_reg, 2'b00}) + $signed({4'b0000, a_r_reg})
                    - $signed({4'b0000, a_g_reg});
            end
        endcase
    end

    assign num   = raw[VB+2:0];
    assign other = TWO_F - a_sum_reg;
    assign den   = (a_sum_reg < other) ? a_sum_reg : other;
    assign sum1  = a_sum_reg + 1'b1;

    assign side.light  = sum1[VB:1];
    assign side.zero_c = (a_c_reg == '0);
    assign side.sat_ok = (a_sum_reg != '0) && (a_sum_reg != TWO_F);

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk) begin
        if (enable)
        begin
            b_hue_dvd_reg <= {1'b0, num, {VB{1'b0}}} + DW'(c3);
            b_hue_dvs_reg <= c6;
            b_sat_dvd_reg <= {4'b0000, a_c_reg, {VB{1'b0}}} - DW'(a_c_reg)
                           + DW'(den[VB:1]);
            b_sat_dvs_reg <= SW'(den);
            b_side_reg    <= side;
        end
    end

    // dividers
    logic          hue_valid;
    logic          sat_valid;
    logic [QW-1:0] hue_q, sat_q;

    rhc_div u_hue_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (enable),
        .in_valid  (b_valid_reg),
        .dividend  (b_hue_dvd_reg),
        .divisor   (b_hue_dvs_reg),
        .out_valid (hue_valid),
        .quotient  (hue_q)
    );

    rhc_div u_sat_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (enable),
        .in_valid  (b_valid_reg),
        .dividend  (b_sat_dvd_reg),
        .divisor   (b_sat_dvs_reg),
        .out_valid (sat_valid),
        .quotient  (sat_q)
    );

    // HSL to RGB path
    rhc_pkg::trip_t hsl_rgb;

    rhc_hsl2rgb u_hsl2rgb (
        .clk   (clk),
        .en    (enable),
        .hue   (s1_a_reg),
        .sat   (s1_b_reg),
        .light (s1_c_reg),
        .rgb   (hsl_rgb)
    );

    // alignment lines
    rhc_pkg::rgb_side_t side_line_reg  [QW];
    rhc_pkg::trip_t     hsl_line_reg   [rhc_pkg::HSL_PAD];
    logic               op_line_reg    [rhc_pkg::OP_DELAY];
    rhc_pkg::val_t      alpha_line_reg [rhc_pkg::OP_DELAY];

    always_ff @(posedge clk) begin
        if (enable)
        begin
            side_line_reg[0]  <= b_side_reg;
            hsl_line_reg[0]   <= hsl_rgb;
            op_line_reg[0]    <= s1_op_reg;
            alpha_line_reg[0] <= s1_alpha_reg;
            for (int i = 1; i < QW; i++)
                side_line_reg[i] <= side_line_reg[i-1];
            for (int i = 1; i < rhc_pkg::HSL_PAD; i++)
                hsl_line_reg[i] <= hsl_line_reg[i-1];
            for (int i = 1; i < rhc_pkg::OP_DELAY; i++)
            begin
                op_line_reg[i]    <= op_line_reg[i-1];
                alpha_line_reg[i] <= alpha_line_reg[i-1];
            end
        end
    end

    // output register
    rhc_pkg::rgb_side_t side_d;
    rhc_pkg::val_t      hue_v, sat_v;
    rhc_pkg::trip_t     out_next;
    rhc_pkg::trip_t     out_reg;
    rhc_pkg::val_t      alpha_reg;

    assign side_d = side_line_reg[QW-1];
    assign hue_v  = side_d.zero_c ? '0 : hue_q[VB-1:0];
    assign sat_v  = !side_d.sat_ok ? '0
                  : (sat_q > QW'(rhc_pkg::FULL)) ? rhc_pkg::FULL : sat_q[VB-1:0];

    always_comb begin
        if (op_line_reg[rhc_pkg::OP_DELAY-1] == rhc_pkg::OP_RGB2HSL)
            out_next = '{c0: hue_v, c1: sat_v, c2: side_d.light};
        else
            out_next = hsl_line_reg[rhc_pkg::HSL_PAD-1];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            out_valid_reg <= hue_valid;
        end
    end

    always_ff @(posedge clk) begin
        if (enable)
        begin
            out_reg   <= out_next;
            alpha_reg <= alpha_line_reg[rhc_pkg::OP_DELAY-1];
        end
    end

    assign out_valid     = out_valid_reg;
    assign first_result  = out_reg.c0;
    assign second_result = out_reg.c1;
    assign third_result  = out_reg.c2;
    assign alpha_out     = alpha_reg;

    `RHC_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, s1_valid_reg)
    `RHC_ASSERT_NEXT(a_stall_holds_front, !enable, $stable({s1_valid_reg, a_valid_reg, b_valid_reg}))
    `RHC_ASSERT(a_div_lockstep, sat_valid == hue_valid)

endmodule
